// ===== src/scf_pkg.sv =====
`timescale 1ns / 1ps
// Package for the segment cross fraction block: widths, register indexes,
// result limits and the structs passed between pipeline modules.
// No dependencies.
package scf_pkg;

    localparam int COORD_W         = 16;
    localparam int DIFF_W          = COORD_W + 1;
    localparam int PROD_W          = 2 * DIFF_W;
    localparam int SUM_W           = PROD_W + 1;
    localparam int DEN_W           = SUM_W + 1;
    localparam int FRAC_W          = 32;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = FRAC_W / STEPS_PER_STAGE;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TRACE_START_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACE_START_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACE_END_X   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACE_END_Y   = 2'd3;

    localparam logic [FRAC_W-1:0] FRAC_POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [FRAC_W-1:0] FRAC_NEG_LIMIT = 32'h8000_0000;
    localparam logic [FRAC_W-1:0] FRAC_MISS      = 32'hFFFF_FFFF;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
    } scf_trace_t;

    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
    } scf_wall_t;

    // geometry result handed to the divider
    typedef struct packed {
        logic                    crossed;
        logic                    num_neg;
        logic [SUM_W-1:0]        s1_mag;
        logic signed [DEN_W-1:0] den;
    } scf_geom_t;

    // state of one request inside the divider
    typedef struct packed {
        logic              crossed;
        logic              num_neg;
        logic              den_zero;
        logic              q_neg;
        logic              ovf;
        logic [DEN_W-1:0]  den_mag;
        logic [DEN_W-1:0]  rem;
        logic [FRAC_W-1:0] nq;
    } scf_div_t;

endpackage

// ===== src/scf_channels.sv =====
`timescale 1ns / 1ps
// Stream channels of the segment cross fraction block: wall requests in,
// crossing results out. Depends on scf_pkg.
interface scf_wall_if
    import scf_pkg::*;
;
    logic   valid;
    logic   ready;
    coord_t first_end_x;
    coord_t first_end_y;
    coord_t second_end_x;
    coord_t second_end_y;

    modport source (
        output valid, first_end_x, first_end_y, second_end_x, second_end_y,
        input  ready
    );
    modport sink (
        input  valid, first_end_x, first_end_y, second_end_x, second_end_y,
        output ready
    );
endinterface

interface scf_hit_if
    import scf_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              crossed;
    logic [FRAC_W-1:0] fraction;

    modport source (
        output valid, crossed, fraction,
        input  ready
    );
    modport sink (
        input  valid, crossed, fraction,
        output ready
    );
endinterface

// ===== src/scf_geom.sv =====
`timescale 1ns / 1ps
// Geometry front end: differences, cross and dot products, side test and
// the numerator and divisor sums, over four register stages. Uses scf_pkg.
module scf_geom
    import scf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  scf_trace_t trace,
    input  logic       in_valid,
    output logic       in_ready,
    input  scf_wall_t  in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output scf_geom_t  out_data
);

    localparam int NST = 4;

    typedef struct packed {
        logic signed [DIFF_W-1:0] tx;
        logic signed [DIFF_W-1:0] ty;
        logic signed [DIFF_W-1:0] dax;
        logic signed [DIFF_W-1:0] day;
        logic signed [DIFF_W-1:0] dbx;
        logic signed [DIFF_W-1:0] dby;
        logic signed [DIFF_W-1:0] nx;
        logic signed [DIFF_W-1:0] ny;
        logic signed [DIFF_W-1:0] eax;
        logic signed [DIFF_W-1:0] eay;
    } diff_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] sb_l;
        logic signed [PROD_W-1:0] sb_r;
        logic signed [PROD_W-1:0] sa_l;
        logic signed [PROD_W-1:0] sa_r;
        logic signed [PROD_W-1:0] n1;
        logic signed [PROD_W-1:0] n2;
        logic signed [PROD_W-1:0] n3;
        logic signed [PROD_W-1:0] n4;
    } prod_t;

    typedef struct packed {
        logic                    crossed;
        logic signed [SUM_W-1:0] s1;
        logic signed [SUM_W-1:0] s2;
    } sum_t;

    function automatic logic signed [DIFF_W-1:0] diff(input coord_t a, input coord_t b);
        return {a[COORD_W-1], a} - {b[COORD_W-1], b};
    endfunction

    logic [NST-1:0] v_reg;
    logic [NST-1:0] adv;

    diff_t     d_reg, d_next;
    prod_t     p_reg, p_next;
    sum_t      s_reg, s_next;
    scf_geom_t g_reg, g_next;

    // a stage loads when it is empty or its contents move on
    always_comb
    begin
        adv[NST-1] = !v_reg[NST-1] || out_ready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[NST-1];
    assign out_data  = g_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (adv[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_comb
    begin
        d_next.tx  = diff(trace.end_x, trace.start_x);
        d_next.ty  = diff(trace.end_y, trace.start_y);
        d_next.dax = diff(in_data.ax, trace.start_x);
        d_next.day = diff(in_data.ay, trace.start_y);
        d_next.dbx = diff(in_data.bx, trace.start_x);
        d_next.dby = diff(in_data.by, trace.start_y);
        d_next.nx  = diff(in_data.ay, in_data.by);
        d_next.ny  = diff(in_data.bx, in_data.ax);
        d_next.eax = diff(trace.end_x, in_data.ax);
        d_next.eay = diff(trace.end_y, in_data.ay);
    end

    always_comb
    begin
        p_next.sb_l = d_reg.ty * d_reg.dbx;
        p_next.sb_r = d_reg.dby * d_reg.tx;
        p_next.sa_l = d_reg.ty * d_reg.dax;
        p_next.sa_r = d_reg.day * d_reg.tx;
        p_next.n1   = d_reg.nx * d_reg.dax;
        p_next.n2   = d_reg.ny * d_reg.day;
        p_next.n3   = d_reg.nx * d_reg.eax;
        p_next.n4   = d_reg.ny * d_reg.eay;
    end

    // crossed when the two endpoints give different results for the strict less-than side test
    always_comb
    begin
        s_next.crossed = (p_reg.sa_l < p_reg.sa_r) != (p_reg.sb_l < p_reg.sb_r);
        s_next.s1      = p_reg.n1 + p_reg.n2;
        s_next.s2      = p_reg.n3 + p_reg.n4;
    end

    always_comb
    begin
        g_next.crossed = s_reg.crossed;
        g_next.num_neg = s_reg.s1[SUM_W-1];
        g_next.s1_mag  = s_reg.s1[SUM_W-1] ? (~s_reg.s1 + 1'b1) : s_reg.s1;
        g_next.den     = s_reg.s1 + s_reg.s2;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            d_reg <= d_next;
        end
        if (adv[1])
        begin
            p_reg <= p_next;
        end
        if (adv[2])
        begin
            s_reg <= s_next;
        end
        if (adv[3])
        begin
            g_reg <= g_next;
        end
    end

endmodule

// ===== src/scf_div_stage.sv =====
`timescale 1ns / 1ps
// One stage of the restoring divider: two quotient bits per request,
// with its own valid bit and stall handshake. Uses scf_pkg.
module scf_div_stage
    import scf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  scf_div_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output scf_div_t out_data
);

    logic           valid_reg;
    scf_div_t       data_reg;
    scf_div_t       data_next;
    logic [DEN_W:0] trial;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // numerator bits shift out of the top of nq, quotient bits in at the bottom
    always_comb
    begin
        data_next = in_data;
        trial     = '0;
        for (int k = 0; k < STEPS_PER_STAGE; k++)
        begin
            trial = {data_next.rem, data_next.nq[FRAC_W-1]};
            if (trial >= {1'b0, data_next.den_mag})
            begin
                trial        = trial - {1'b0, data_next.den_mag};
                data_next.nq = {data_next.nq[FRAC_W-2:0], 1'b1};
            end
            else
            begin
                data_next.nq = {data_next.nq[FRAC_W-2:0], 1'b0};
            end
            data_next.rem = trial[DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== src/scf_div.sv =====
`timescale 1ns / 1ps
// Pipelined saturating divider: magnitudes, overflow check, a chain of
// scf_div_stage units and the signed, saturated result register.
// Uses scf_pkg and scf_div_stage.
module scf_div
    import scf_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  scf_geom_t         in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_crossed,
    output logic [FRAC_W-1:0] out_fraction
);

    localparam int NUM_W = SUM_W + FRAC_BITS;
    localparam int HI_W  = NUM_W - FRAC_W;

    typedef struct packed {
        logic             crossed;
        logic             num_neg;
        logic             den_zero;
        logic             q_neg;
        logic [DEN_W-1:0] den_mag;
        logic [SUM_W-1:0] s1_mag;
    } mag_t;

    logic a_valid_reg, a_adv;
    mag_t a_reg, a_next;

    logic     b_valid_reg, b_adv;
    scf_div_t b_data_reg, b_next;

    logic     [NUM_W-1:0] num_mag;
    logic     [HI_W-1:0]  num_hi;
    logic     [DEN_W-1:0] hi_ext;

    logic     st_valid [DIV_STAGES+1];
    logic     st_ready [DIV_STAGES+1];
    scf_div_t st_data  [DIV_STAGES+1];

    logic              o_valid_reg, o_adv;
    logic              o_crossed_reg;
    logic [FRAC_W-1:0] o_fraction_reg, o_fraction_next;
    scf_div_t          fin;

    assign o_adv    = !o_valid_reg || out_ready;
    assign b_adv    = !b_valid_reg || st_ready[0];
    assign a_adv    = !a_valid_reg || b_adv;
    assign in_ready = a_adv;

    always_comb
    begin
        a_next.crossed  = in_data.crossed;
        a_next.num_neg  = in_data.num_neg;
        a_next.den_zero = (in_data.den == '0);
        a_next.q_neg    = in_data.num_neg ^ in_data.den[DEN_W-1];
        a_next.den_mag  = in_data.den[DEN_W-1] ? (~in_data.den + 1'b1) : in_data.den;
        a_next.s1_mag   = in_data.s1_mag;
    end

    // quotient reaches 2^32 exactly when the bits above the low word are
    // not below the divisor; a zero divisor also lands here
    always_comb
    begin
        num_mag         = {a_reg.s1_mag, {FRAC_BITS{1'b0}}};
        num_hi          = num_mag[NUM_W-1:FRAC_W];
        hi_ext          = DEN_W'(num_hi);
        b_next.crossed  = a_reg.crossed;
        b_next.num_neg  = a_reg.num_neg;
        b_next.den_zero = a_reg.den_zero;
        b_next.q_neg    = a_reg.q_neg;
        b_next.ovf      = (hi_ext >= a_reg.den_mag);
        b_next.den_mag  = a_reg.den_mag;
        b_next.rem      = hi_ext;
        b_next.nq       = num_mag[FRAC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_adv)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_adv)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (o_adv)
            begin
                o_valid_reg <= st_valid[DIV_STAGES];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            a_reg <= a_next;
        end
        if (b_adv)
        begin
            b_data_reg <= b_next;
        end
        if (o_adv)
        begin
            o_crossed_reg  <= fin.crossed;
            o_fraction_reg <= o_fraction_next;
        end
    end

    assign st_valid[0]          = b_valid_reg;
    assign st_data[0]           = b_data_reg;
    assign st_ready[DIV_STAGES] = o_adv;

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_step
        scf_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (st_valid[g]),
            .in_ready  (st_ready[g]),
            .in_data   (st_data[g]),
            .out_valid (st_valid[g+1]),
            .out_ready (st_ready[g+1]),
            .out_data  (st_data[g+1])
        );
    end

    assign fin = st_data[DIV_STAGES];

    always_comb
    begin
        priority if (!fin.crossed)
        begin
            o_fraction_next = FRAC_MISS;
        end
        else if (fin.den_zero)
        begin
            o_fraction_next = fin.num_neg ? FRAC_NEG_LIMIT : FRAC_POS_LIMIT;
        end
        else if (fin.ovf)
        begin
            o_fraction_next = fin.q_neg ? FRAC_NEG_LIMIT : FRAC_POS_LIMIT;
        end
        else if (fin.q_neg)
        begin
            o_fraction_next = (fin.nq > FRAC_NEG_LIMIT) ? FRAC_NEG_LIMIT : (~fin.nq + 1'b1);
        end
        else
        begin
            o_fraction_next = fin.nq[FRAC_W-1] ? FRAC_POS_LIMIT : fin.nq;
        end
    end

    assign out_valid    = o_valid_reg;
    assign out_crossed  = o_crossed_reg;
    assign out_fraction = o_fraction_reg;

endmodule

// ===== src/segment_cross_fraction.sv =====
`timescale 1ns / 1ps
// Top level: trace registers, geometry front end and pipelined divider.
// Depends on scf_pkg, scf_channels, scf_geom, scf_div.
//
//  channel  dir  handshake      payload
//  wall     in   valid/ready    first_end_x/y, second_end_x/y (16b signed)
//  hit      out  valid/ready    crossed (1b), fraction (32b, 16.16 signed)
//  cfg      in   cfg_wr_en      cfg_index (2b), cfg_data (16b)
//
// One request per cycle in and out while hit.ready allows; the path runs through
// 4 geometry stages, 2 divider set-up stages, 16 divider stages of 2 quotient
// bits each and the output register.
// rst_n clears all valid bits and the trace registers to zero.
// Every stage holds under a stall and loads again once it moves on, so
// bubbles close up and a full pipeline stalls back to wall.ready.
module segment_cross_fraction
    import scf_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    scf_wall_if.sink             wall,
    scf_hit_if.source            hit,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data
);

    coord_t trace_start_x_reg;
    coord_t trace_start_y_reg;
    coord_t trace_end_x_reg;
    coord_t trace_end_y_reg;

    scf_trace_t trace;
    scf_wall_t  wall_data;
    logic       geom_valid;
    logic       geom_ready;
    scf_geom_t  geom_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trace_start_x_reg <= '0;
            trace_start_y_reg <= '0;
            trace_end_x_reg   <= '0;
            trace_end_y_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_TRACE_START_X: trace_start_x_reg <= cfg_data;
                CFG_TRACE_START_Y: trace_start_y_reg <= cfg_data;
                CFG_TRACE_END_X:   trace_end_x_reg   <= cfg_data;
                CFG_TRACE_END_Y:   trace_end_y_reg   <= cfg_data;
                default:           trace_end_y_reg   <= trace_end_y_reg;
            endcase
        end
    end

    always_comb
    begin
        trace.start_x = trace_start_x_reg;
        trace.start_y = trace_start_y_reg;
        trace.end_x   = trace_end_x_reg;
        trace.end_y   = trace_end_y_reg;
        wall_data.ax  = wall.first_end_x;
        wall_data.ay  = wall.first_end_y;
        wall_data.bx  = wall.second_end_x;
        wall_data.by  = wall.second_end_y;
    end

    scf_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .trace     (trace),
        .in_valid  (wall.valid),
        .in_ready  (wall.ready),
        .in_data   (wall_data),
        .out_valid (geom_valid),
        .out_ready (geom_ready),
        .out_data  (geom_data)
    );

    scf_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (geom_valid),
        .in_ready     (geom_ready),
        .in_data      (geom_data),
        .out_valid    (hit.valid),
        .out_ready    (hit.ready),
        .out_crossed  (hit.crossed),
        .out_fraction (hit.fraction)
    );

endmodule

// ===== src/scf_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for segment_cross_fraction, attached by bind.
// Depends on scf_pkg and the top level's ports.
module scf_checker
    import scf_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              wall_ready,
    input logic              hit_valid,
    input logic              hit_ready,
    input logic              hit_crossed,
    input logic [FRAC_W-1:0] hit_fraction
);

    // no result may show while reset is held
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !hit_valid)
        else $error("result valid during reset");

    a_miss_code: assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid && !hit_crossed |-> hit_fraction == FRAC_MISS)
        else $error("uncrossed wall without all-ones fraction");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid && !hit_ready |=> hit_valid && $stable(hit_fraction)
            && $stable(hit_crossed))
        else $error("stalled result changed");

    // with the output free to move, the whole pipeline moves: input is open
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !hit_valid || hit_ready |-> wall_ready)
        else $error("input blocked while output side is free");

endmodule

bind segment_cross_fraction scf_checker u_scf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .wall_ready   (wall.ready),
    .hit_valid    (hit.valid),
    .hit_ready    (hit.ready),
    .hit_crossed  (hit.crossed),
    .hit_fraction (hit.fraction)
);

// ===== bench/tb_segment_cross_fraction.sv =====
`timescale 1ns / 1ps
// Testbench for segment_cross_fraction: streams wall requests against many trace
// settings and checks every hit result against a predictor in this file.
// Depends on scf_pkg, scf_channels and the segment_cross_fraction RTL.
module tb_segment_cross_fraction;
    import scf_pkg::*;

    localparam int     FRAC_BITS      = 16;
    localparam int     PIPE_LATENCY   = 23;
    localparam int     WATCHDOG_LIMIT = 3000;
    localparam int     PRINT_LIMIT    = 100;
    localparam coord_t COORD_MAX      = 16'sh7FFF;
    localparam coord_t COORD_MIN      = 16'sh8000;

    typedef struct packed {
        logic              crossed;
        logic [FRAC_W-1:0] fraction;
    } crossing_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0]   cfg_data;

    scf_wall_if wall_ch ();
    scf_hit_if  hit_ch ();

    segment_cross_fraction #(
        .FRAC_BITS (FRAC_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .wall      (wall_ch),
        .hit       (hit_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // trace registers as the predictor sees them
    longint trace_sx, trace_sy, trace_ex, trace_ey;

    crossing_t pending_hits[$];

    int error_count    = 0;
    int walls_sent     = 0;
    int hits_checked   = 0;
    int crossed_seen   = 0;
    int saturated_seen = 0;
    int trace_settings = 0;
    int idle_cycles    = 0;
    int hold_request   = 0;
    bit tx_idling      = 1'b1;
    bit rx_idling      = 1'b1;

    always #4 clk = ~clk;

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    function automatic crossing_t predict_crossing(input scf_wall_t w);
        longint    ax, ay, bx, by, tx, ty, dx, dy, nx, ny, s1, s2, num, den, q;
        logic      side_a, side_b;
        crossing_t res;
        ax = longint'($signed(w.ax));
        ay = longint'($signed(w.ay));
        bx = longint'($signed(w.bx));
        by = longint'($signed(w.by));
        tx = trace_ex - trace_sx;
        ty = trace_ey - trace_sy;

        dx = bx - trace_sx;
        dy = by - trace_sy;
        side_b = (ty * dx) < (dy * tx);
        dx = ax - trace_sx;
        dy = ay - trace_sy;
        side_a = (ty * dx) < (dy * tx);

        if (side_a == side_b)
        begin
            res.crossed  = 1'b0;
            res.fraction = FRAC_MISS;
            return res;
        end

        // project start and end onto the wall normal
        nx  = ay - by;
        ny  = bx - ax;
        s1  = nx * dx + ny * dy;
        s2  = nx * (trace_ex - ax) + ny * (trace_ey - ay);
        num = s1 * (longint'(1) << FRAC_BITS);
        den = s1 + s2;

        res.crossed = 1'b1;
        if (den == 0)
            res.fraction = (num >= 0) ? FRAC_POS_LIMIT : FRAC_NEG_LIMIT;
        else
        begin
            q = num / den;
            if (q > 64'sd2147483647)
                res.fraction = FRAC_POS_LIMIT;
            else if (q < -64'sd2147483648)
                res.fraction = FRAC_NEG_LIMIT;
            else
                res.fraction = q[FRAC_W-1:0];
        end
        return res;
    endfunction

    function automatic scf_wall_t make_wall(input coord_t ax, input coord_t ay,
                                            input coord_t bx, input coord_t by);
        scf_wall_t w;
        w.ax = ax;
        w.ay = ay;
        w.bx = bx;
        w.by = by;
        return w;
    endfunction

    function automatic coord_t near_coord(input longint centre, input longint span);
        longint v;
        v = centre + longint'($urandom_range(0, 2 * span)) - span;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return coord_t'(v);
    endfunction

    // mostly walls scattered around the trace so that crossings are common
    function automatic scf_wall_t random_wall();
        longint px, py, span, t;
        if ($urandom_range(0, 9) < 3)
            return scf_wall_t'({$urandom, $urandom});
        case ($urandom_range(0, 3))
            0: span = 4;
            1: span = 64;
            2: span = 2048;
            default: span = 40000;
        endcase
        t  = longint'($urandom_range(0, 1024)) - 256;
        px = trace_sx + (trace_ex - trace_sx) * t / 512;
        py = trace_sy + (trace_ey - trace_sy) * t / 512;
        return make_wall(near_coord(px, span), near_coord(py, span),
                         near_coord(px, span), near_coord(py, span));
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input coord_t value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_TRACE_START_X: trace_sx = value;
            CFG_TRACE_START_Y: trace_sy = value;
            CFG_TRACE_END_X:   trace_ex = value;
            CFG_TRACE_END_Y:   trace_ey = value;
            default: ;
        endcase
    endtask

    task automatic write_trace(input coord_t sx, input coord_t sy,
                               input coord_t ex, input coord_t ey);
        write_reg(CFG_TRACE_START_X, sx);
        write_reg(CFG_TRACE_START_Y, sy);
        write_reg(CFG_TRACE_END_X, ex);
        write_reg(CFG_TRACE_END_Y, ey);
        cfg_wr_en <= 1'b0;
        trace_settings++;
    endtask

    task automatic send_wall(input scf_wall_t w);
        crossing_t want;
        if (tx_idling && $urandom_range(0, 4) == 0)
        begin
            wall_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        wall_ch.valid        <= 1'b1;
        wall_ch.first_end_x  <= w.ax;
        wall_ch.first_end_y  <= w.ay;
        wall_ch.second_end_x <= w.bx;
        wall_ch.second_end_y <= w.by;
        do
            @(posedge clk);
        while (!wall_ch.ready);
        want = predict_crossing(w);
        pending_hits.push_back(want);
        walls_sent++;
        if (want.crossed)
        begin
            crossed_seen++;
            if (want.fraction == FRAC_POS_LIMIT || want.fraction == FRAC_NEG_LIMIT)
                saturated_seen++;
        end
    endtask

    // drop valid and wait for every outstanding request to come back
    task automatic settle_pipeline();
        wall_ch.valid <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // trace registers still at reset: zero-length trace, nothing crosses
    task automatic test_reset_trace();
        send_wall(make_wall(0, -50, 0, 50));
        send_wall(make_wall(-10, 10, 10, -10));
        send_wall(make_wall(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
        send_wall(make_wall(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
    endtask

    task automatic test_directed_walls();
        settle_pipeline();
        write_trace(-100, 0, 100, 0);
        send_wall(make_wall(0, -50, 0, 50));
        send_wall(make_wall(0, 50, 0, -50));
        send_wall(make_wall(0, 0, 0, 50));          // endpoint on the trace line
        send_wall(make_wall(0, -50, 0, 0));
        send_wall(make_wall(5, 5, 5, 5));           // zero-length wall
        send_wall(make_wall(200, -10, 200, 10));    // beyond the trace end
        send_wall(make_wall(-300, -1, -300, 1));    // behind the trace start
        send_wall(make_wall(-50, 10, 50, 10));      // parallel
        settle_pipeline();
        write_trace(7, 7, 7, 7);
        send_wall(make_wall(0, -50, 0, 50));
        settle_pipeline();
        // one-unit traces with far walls push the quotient past both limits
        write_trace(COORD_MIN, 0, -32767, 0);
        send_wall(make_wall(COORD_MAX, -1, COORD_MAX, 1));
        send_wall(make_wall(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX));
        settle_pipeline();
        write_trace(32766, 0, COORD_MAX, 0);
        send_wall(make_wall(COORD_MIN, -1, COORD_MIN, 1));
        settle_pipeline();
        write_trace(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        send_wall(make_wall(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
        send_wall(make_wall(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
        send_wall(make_wall(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
        settle_pipeline();
        write_trace(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
        send_wall(make_wall(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
    endtask

    task automatic test_random_traces();
        coord_t a, b, c;
        for (int phase = 0; phase < 8; phase++)
        begin
            settle_pipeline();
            case (phase % 4)
                0: write_trace(coord_t'($urandom), coord_t'($urandom),
                               coord_t'($urandom), coord_t'($urandom));
                1: write_trace(coord_t'(int'($urandom_range(0, 400)) - 200),
                               coord_t'(int'($urandom_range(0, 400)) - 200),
                               coord_t'(int'($urandom_range(0, 400)) - 200),
                               coord_t'(int'($urandom_range(0, 400)) - 200));
                2:
                begin
                    a = coord_t'($urandom);
                    b = coord_t'($urandom);
                    c = coord_t'($urandom);
                    if ($urandom_range(0, 1))
                        write_trace(a, c, b, c);
                    else
                        write_trace(c, a, c, b);
                end
                default: write_trace($urandom_range(0, 1) ? COORD_MAX : COORD_MIN,
                                     $urandom_range(0, 1) ? COORD_MAX : COORD_MIN,
                                     $urandom_range(0, 1) ? COORD_MAX : COORD_MIN,
                                     $urandom_range(0, 1) ? COORD_MAX : COORD_MIN);
            endcase
            tx_idling = (phase % 3 != 1);
            rx_idling = (phase % 3 != 2);
            repeat (150) send_wall(random_wall());
        end
        tx_idling = 1'b1;
        rx_idling = 1'b1;
    endtask

    // hit side held off long enough for the pipeline to fill and stall wall
    task automatic test_output_holdoff();
        settle_pipeline();
        tx_idling    = 1'b0;
        hold_request = 150;
        repeat (80) send_wall(random_wall());
        tx_idling = 1'b1;
    endtask

    task automatic test_drain_pause();
        repeat (40) send_wall(random_wall());
        settle_pipeline();
        repeat (40) send_wall(random_wall());
    endtask

    task automatic test_full_rate();
        settle_pipeline();
        write_trace(coord_t'(int'($urandom_range(0, 4000)) - 2000),
                    coord_t'(int'($urandom_range(0, 4000)) - 2000),
                    coord_t'(int'($urandom_range(0, 4000)) - 2000),
                    coord_t'(int'($urandom_range(0, 4000)) - 2000));
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        repeat (300) send_wall(random_wall());
    endtask

    // hit receiver
    initial
    begin
        forever
        begin
            if (hold_request > 0)
            begin
                hit_ch.ready <= 1'b0;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
            end
            else if (rx_idling && $urandom_range(0, 3) == 0)
            begin
                hit_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                hit_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        crossing_t want;
        if (rst_n && hit_ch.valid && hit_ch.ready)
        begin
            if (pending_hits.size() == 0)
                report_mismatch($sformatf("result with no request outstanding: crossed=%0b fraction=%h",
                                          hit_ch.crossed, hit_ch.fraction));
            else
            begin
                want = pending_hits.pop_front();
                if (hit_ch.crossed !== want.crossed)
                    report_mismatch($sformatf("crossed: expected %0b got %0b",
                                              want.crossed, hit_ch.crossed));
                if (hit_ch.fraction !== want.fraction)
                    report_mismatch($sformatf("fraction: expected %h got %h",
                                              want.fraction, hit_ch.fraction));
                hits_checked++;
            end
        end
    end

    // watchdog: cycles without any handshake on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (wall_ch.valid && wall_ch.ready) || (hit_ch.valid && hit_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] watchdog: no traffic for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, pending_hits.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_index            = CFG_TRACE_START_X;
        cfg_data             = '0;
        wall_ch.valid        = 1'b0;
        wall_ch.first_end_x  = '0;
        wall_ch.first_end_y  = '0;
        wall_ch.second_end_x = '0;
        wall_ch.second_end_y = '0;
        trace_sx             = 0;
        trace_sy             = 0;
        trace_ex             = 0;
        trace_ey             = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_trace();
        test_directed_walls();
        test_random_traces();
        test_output_holdoff();
        test_drain_pause();
        test_full_rate();

        settle_pipeline();
        repeat (PIPE_LATENCY) @(posedge clk);

        $display("Sent %0d wall requests over %0d trace settings: %0d crossings, %0d saturated.",
                 walls_sent, trace_settings, crossed_seen, saturated_seen);
        $display("Checked %0d results under random stalls, a long hold-off and full rate; %0d mismatches.",
                 hits_checked, error_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
